/* design/swcs_pkg.sv */
// Shared types, codes and constants of the stop-and-wait chunk sender.
`timescale 1ns / 1ps
package swcs_pkg;

  localparam int unsigned CHUNK_BYTES_DEF = 64;
  localparam int unsigned LEN_W           = 23;
  localparam int unsigned TICKS_W         = 16;
  localparam int unsigned RETRY_W         = 8;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned IDX_W           = 16;
  localparam int unsigned CLEN_W          = 7;
  localparam int unsigned REASON_W        = 2;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam int unsigned CHUNK_W         = 17;
  localparam int unsigned MAX_CHUNKS      = 65536;
  localparam int unsigned WAIT_W          = 17;
  localparam int unsigned RETRIES_W       = 9;

  localparam logic [LEN_W-1:0]   FILE_LENGTH_RST = '0;
  localparam logic [TICKS_W-1:0] TIMEOUT_RST     = 16'd2000;
  localparam logic [RETRY_W-1:0] RETRY_RST       = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILE_LENGTH = 2'd0,
    CFG_ACK_TIMEOUT = 2'd1,
    CFG_RETRY_LIMIT = 2'd2
  } cfg_idx_t;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_START     = 3'd1;
  localparam logic [OP_W-1:0] OP_HDR_ACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_CHUNK_ACK = 3'd3;

  localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEADER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHUNK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DONE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABORT  = 3'd4;

  localparam logic [REASON_W-1:0] RSN_NONE     = 2'd0;
  localparam logic [REASON_W-1:0] RSN_SIZE     = 2'd1;
  localparam logic [REASON_W-1:0] RSN_HDR_RTRY = 2'd2;
  localparam logic [REASON_W-1:0] RSN_CHK_RTRY = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0]   file_length;
    logic [TICKS_W-1:0] ack_timeout_ticks;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [LEN_W-1:0] ack_value;
  } req_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    chunk_index;
    logic [CLEN_W-1:0]   chunk_length;
    logic [REASON_W-1:0] abort_reason;
    logic                busy_res;
  } res_t;

endpackage

/* design/stop_and_wait_chunk_sender_core.sv */
// Top level of the stop-and-wait chunk sender: request and result registers.
//
// Usage: requests enter on the in_ stream; in_tuser carries the operation
// (tick, start, header ack, chunk ack, other) and in_tdata the ack value.
// Every request yields exactly one result on the out_ stream; out_tuser
// carries the command (none, header, chunk, done, abort) and out_tdata the
// chunk index, chunk length, abort reason and busy flag.
// Flow: an accepted request is held in the request register, decoded by the
// state machine once the result register is free, and shown on out_ from there.
// Throughput: one request per cycle while out_tready stays high; the
// request register fills while a result waits, so in_tready drops only
// when both stages hold data.
// Configuration: cfg_we writes file length (index 0), ack timeout in ticks
// (index 1) or retry limit (index 2) at the clock edge; write only while idle.
// Reset: synchronous, active low; the sender goes idle, both stages empty,
// registers take their defaults (length 0, timeout 2000, retries 10).
// Stall: while out_tready is low the result holds and one more request may
// be taken; further requests wait at in_tready low.
`timescale 1ns / 1ps
module stop_and_wait_chunk_sender_core #(
  parameter int unsigned CHUNK_BYTES = swcs_pkg::CHUNK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,  // [22:0] ack_value
  input  logic [swcs_pkg::OP_W-1:0]      in_tuser,  // [2:0] operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] chunk_index, [22:16] chunk_length, [24:23] abort_reason, [25] busy_res
  output logic [31:0]                    out_tdata,
  output logic [swcs_pkg::CMD_W-1:0]     out_tuser, // [2:0] command
  input  logic                           cfg_we,
  input  logic [swcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swcs_pkg::LEN_W-1:0]     cfg_wdata
);
  import swcs_pkg::*;

  cfg_t cfg;
  req_t req_r;
  res_t res;
  res_t res_r;
  logic req_valid_r;
  logic out_valid_r;
  logic out_free;
  logic step;
  logic in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = req_valid_r && out_free;
  assign in_tready = !req_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  swcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swcs_engine #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        req_valid_r <= 1'b1;
      end else if (step) begin
        req_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.operation <= in_tuser;
      req_r.ack_value <= in_tdata[LEN_W-1:0];
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.command;
  assign out_tdata  = {6'b0, res_r.busy_res, res_r.abort_reason,
                       res_r.chunk_length, res_r.chunk_index};

endmodule

/* design/swcs_cfg_regs.sv */
// Configuration register bank of the stop-and-wait chunk sender.
`timescale 1ns / 1ps
module swcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swcs_pkg::LEN_W-1:0]     cfg_wdata,
  output swcs_pkg::cfg_t                 cfg
);
  import swcs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.file_length       <= FILE_LENGTH_RST;
      cfg_r.ack_timeout_ticks <= TIMEOUT_RST;
      cfg_r.retry_limit       <= RETRY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILE_LENGTH: cfg_r.file_length       <= cfg_wdata;
        CFG_ACK_TIMEOUT: cfg_r.ack_timeout_ticks <= cfg_wdata[TICKS_W-1:0];
        CFG_RETRY_LIMIT: cfg_r.retry_limit       <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/swcs_engine.sv */
// Sender state machine: per-request state update and result decode.
`timescale 1ns / 1ps
module swcs_engine #(
  parameter int unsigned CHUNK_BYTES = swcs_pkg::CHUNK_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  swcs_pkg::req_t req,
  input  swcs_pkg::cfg_t cfg,
  output swcs_pkg::res_t res
);
  import swcs_pkg::*;

  localparam int unsigned START_W = $clog2(MAX_CHUNKS * CHUNK_BYTES + 1);
  localparam int unsigned CMP_W   = (START_W > LEN_W) ? START_W : LEN_W;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_WAIT_HEADER = 2'd1,
    PH_WAIT_CHUNK  = 2'd2
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [CHUNK_W-1:0]   cur_r, cur_nxt;
  logic [START_W-1:0]   start_r, start_nxt;
  logic [WAIT_W-1:0]    wait_r, wait_nxt;
  logic [RETRIES_W-1:0] retries_r, retries_nxt;

  logic [CHUNK_W-1:0]   cand_chunk;
  logic [START_W-1:0]   cand_start;
  logic                 cand_more;
  logic [CLEN_W-1:0]    cand_len;
  logic [CLEN_W-1:0]    cur_len;
  logic [WAIT_W-1:0]    wait_inc;
  logic [RETRIES_W-1:0] retries_inc;
  logic                 timeout;
  logic                 retry_ok;

  function automatic logic [CLEN_W-1:0] chunk_len(input logic [LEN_W-1:0] flen,
                                                  input logic [START_W-1:0] start);
    logic [CMP_W-1:0] fl;
    logic [CMP_W-1:0] st;
    logic [CMP_W-1:0] rest;
    fl   = CMP_W'(flen);
    st   = CMP_W'(start);
    rest = (fl > st) ? (fl - st) : '0;
    if (rest < CMP_W'(CHUNK_BYTES)) begin
      chunk_len = CLEN_W'(rest);
    end else begin
      chunk_len = CLEN_W'(CHUNK_BYTES);
    end
  endfunction

  always_comb begin
    if (req.operation == OP_HDR_ACK) begin
      cand_chunk = '0;
      cand_start = '0;
    end else begin
      cand_chunk = cur_r + CHUNK_W'(1);
      cand_start = start_r + START_W'(CHUNK_BYTES);
    end
    cand_more   = (cand_chunk < CHUNK_W'(MAX_CHUNKS)) &&
                  (CMP_W'(cfg.file_length) > CMP_W'(cand_start));
    cand_len    = chunk_len(cfg.file_length, cand_start);
    cur_len     = chunk_len(cfg.file_length, start_r);
    wait_inc    = (wait_r == WAIT_MAX) ? wait_r : wait_r + WAIT_W'(1);
    timeout     = wait_inc > WAIT_W'(cfg.ack_timeout_ticks);
    retries_inc = retries_r + RETRIES_W'(1);
    retry_ok    = retries_inc <= RETRIES_W'(cfg.retry_limit);
  end

  always_comb begin
    phase_nxt   = phase_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    wait_nxt    = wait_r;
    retries_nxt = retries_r;
    res         = '0;
    res.command = CMD_NONE;

    case (req.operation) inside
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          wait_nxt = wait_inc;
          if (timeout) begin
            retries_nxt = retries_inc;
            if (retry_ok) begin
              wait_nxt = '0;
              if (phase_r == PH_WAIT_HEADER) begin
                res.command = CMD_HEADER;
              end else begin
                res.command      = CMD_CHUNK;
                res.chunk_index  = IDX_W'(cur_r);
                res.chunk_length = cur_len;
              end
            end else begin
              res.command      = CMD_ABORT;
              res.abort_reason = (phase_r == PH_WAIT_HEADER) ? RSN_HDR_RTRY : RSN_CHK_RTRY;
              phase_nxt        = PH_IDLE;
            end
          end
        end
      end
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt   = PH_WAIT_HEADER;
          cur_nxt     = '0;
          start_nxt   = '0;
          wait_nxt    = '0;
          retries_nxt = '0;
          res.command = CMD_HEADER;
        end
      end
      OP_HDR_ACK, OP_CHUNK_ACK: begin
        if (((req.operation == OP_HDR_ACK) && (phase_r == PH_WAIT_HEADER) &&
             (req.ack_value == cfg.file_length)) ||
            ((req.operation == OP_CHUNK_ACK) && (phase_r == PH_WAIT_CHUNK) &&
             (req.ack_value == LEN_W'(cur_r)))) begin
          cur_nxt     = cand_chunk;
          start_nxt   = cand_start;
          wait_nxt    = '0;
          retries_nxt = '0;
          if (cand_more) begin
            phase_nxt        = PH_WAIT_CHUNK;
            res.command      = CMD_CHUNK;
            res.chunk_index  = IDX_W'(cand_chunk);
            res.chunk_length = cand_len;
          end else begin
            phase_nxt   = PH_IDLE;
            res.command = CMD_DONE;
          end
        end else if ((req.operation == OP_HDR_ACK) && (phase_r == PH_WAIT_HEADER)) begin
          res.command      = CMD_ABORT;
          res.abort_reason = RSN_SIZE;
          phase_nxt        = PH_IDLE;
        end
      end
      default: ;
    endcase

    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cur_r     <= '0;
      start_r   <= '0;
      wait_r    <= '0;
      retries_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cur_r     <= cur_nxt;
      start_r   <= start_nxt;
      wait_r    <= wait_nxt;
      retries_r <= retries_nxt;
    end
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the stop-and-wait chunk sender, built around a behavioural predictor.
`timescale 1ns / 1ps
module testbench;
  import swcs_pkg::*;

  localparam int unsigned CHUNK       = CHUNK_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SESSIONS    = 15;
  localparam int unsigned SESSION_LEN = 60;
  localparam int unsigned FULL_ACKS   = 16;
  localparam logic [OP_W-1:0]      OP_OTHER   = 3'd4;
  localparam logic [OP_W-1:0]      OP_RSVD    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [WAIT_W-1:0]    WAIT_SAT   = '1;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_HDR, PH_WAIT_CHUNK} phase_t;

  typedef struct packed {
    logic                reconf;
    logic [OP_W-1:0]     op;
    logic [LEN_W-1:0]    val;
    logic [TICKS_W-1:0]  tmo;
    logic [RETRY_W-1:0]  rty;
    logic                typed;
    res_t                want;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;   // [22:0] ack_value
  logic [OP_W-1:0]      in_tuser = '0;   // [2:0] operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [15:0] chunk_index, [22:16] chunk_length, [24:23] abort_reason, [25] busy_res
  logic [31:0]          out_tdata;
  logic [CMD_W-1:0]     out_tuser;       // [2:0] command
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_wdata = '0;

  stop_and_wait_chunk_sender_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sender state as predicted
  phase_t               ph = PH_IDLE;
  logic [CHUNK_W-1:0]   cur = '0;
  logic [WAIT_W-1:0]    waited = '0;
  logic [RETRIES_W-1:0] tries = '0;
  logic [LEN_W-1:0]     cfg_len = FILE_LENGTH_RST;
  logic [TICKS_W-1:0]   cfg_tmo = TIMEOUT_RST;
  logic [RETRY_W-1:0]   cfg_rty = RETRY_RST;

  res_t       cmd_q[$];
  step_row_t  steps[$];
  res_t       oldest;
  bit         no_idle = 1'b0;
  int         hold_left = 0;
  int unsigned n_err = 0, n_items = 0, n_results = 0;
  int unsigned n_done = 0, n_abort = 0, n_cfg = 0;

  function automatic int unsigned count_chunks();
    int unsigned n;
    n = (32'(cfg_len) + CHUNK - 1) / CHUNK;
    return (n > MAX_CHUNKS) ? MAX_CHUNKS : n;
  endfunction

  function automatic logic [CLEN_W-1:0] len_of(input logic [CHUNK_W-1:0] k);
    int unsigned first, rest;
    first = 32'(k) * CHUNK;
    rest = (32'(cfg_len) > first) ? 32'(cfg_len) - first : 0;
    if (rest > CHUNK) rest = CHUNK;
    return rest[CLEN_W-1:0];
  endfunction

  function automatic res_t order_next();
    res_t r;
    r = '0;
    waited = '0;
    tries = '0;
    if (32'(cur) < count_chunks()) begin
      ph = PH_WAIT_CHUNK;
      r.command = CMD_CHUNK;
      r.chunk_index = cur[IDX_W-1:0];
      r.chunk_length = len_of(cur);
    end else begin
      ph = PH_IDLE;
      r.command = CMD_DONE;
    end
    return r;
  endfunction

  function automatic res_t predict(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] val);
    res_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        if (ph != PH_IDLE) begin
          if (waited != WAIT_SAT) waited = waited + 1'b1;
          if (waited > cfg_tmo) begin
            tries = tries + 1'b1;
            if (tries <= cfg_rty) begin
              waited = '0;
              if (ph == PH_WAIT_HDR) begin
                r.command = CMD_HEADER;
              end else begin
                r.command = CMD_CHUNK;
                r.chunk_index = cur[IDX_W-1:0];
                r.chunk_length = len_of(cur);
              end
            end else begin
              r.command = CMD_ABORT;
              r.abort_reason = (ph == PH_WAIT_HDR) ? RSN_HDR_RTRY : RSN_CHK_RTRY;
              ph = PH_IDLE;
            end
          end
        end
      end
      OP_START: begin
        if (ph == PH_IDLE) begin
          ph = PH_WAIT_HDR;
          cur = '0;
          waited = '0;
          tries = '0;
          r.command = CMD_HEADER;
        end
      end
      OP_HDR_ACK: begin
        if (ph == PH_WAIT_HDR) begin
          if (val == cfg_len) begin
            cur = '0;
            r = order_next();
          end else begin
            r.command = CMD_ABORT;
            r.abort_reason = RSN_SIZE;
            ph = PH_IDLE;
          end
        end
      end
      OP_CHUNK_ACK: begin
        if (ph == PH_WAIT_CHUNK && val == cur) begin
          cur = cur + 1'b1;
          r = order_next();
        end
      end
      default: ;
    endcase
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  function automatic res_t res_of(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                  input logic [CLEN_W-1:0] len, input logic [REASON_W-1:0] rsn,
                                  input logic busy);
    res_t r;
    r.command = cmd;
    r.chunk_index = idx;
    r.chunk_length = len;
    r.abort_reason = rsn;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic step_row_t req_row(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] val);
    step_row_t s;
    s = '0;
    s.op = op;
    s.val = val;
    return s;
  endfunction

  function automatic step_row_t typed_row(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] val,
                                          input res_t want);
    step_row_t s;
    s = req_row(op, val);
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic step_row_t cfg_row(input logic [LEN_W-1:0] len, input logic [TICKS_W-1:0] tmo,
                                        input logic [RETRY_W-1:0] rty);
    step_row_t s;
    s = '0;
    s.reconf = 1'b1;
    s.val = len;
    s.tmo = tmo;
    s.rty = rty;
    return s;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(input string msg);
    n_err++;
    if (n_err <= 30) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d want %0d", n_results, name, got, want));
  endtask

  task automatic send_req(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] val,
                          input logic typed, input res_t want);
    int gap;
    res_t guess;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val};
    do @(posedge clk); while (!in_tready);
    guess = predict(op, val);
    cmd_q.push_back(typed ? want : guess);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] tmo_word,
                            input logic [LEN_W-1:0] rty_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= tmo_word;
    @(posedge clk);
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= rty_word;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= LEN_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_len = len;
    cfg_tmo = tmo_word[TICKS_W-1:0];
    cfg_rty = rty_word[RETRY_W-1:0];
    n_cfg++;
  endtask

  task automatic random_step();
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] val;
    logic             noise;
    int unsigned      r;
    r = $urandom_range(0, 99);
    val = LEN_W'($urandom);
    op = OP_OTHER;
    noise = 1'b1;
    case (ph)
      PH_IDLE: begin
        if (r < 75) begin
          op = OP_START;
          noise = 1'b0;
        end
      end
      PH_WAIT_HDR: begin
        noise = 1'b0;
        if (r < 25) op = OP_TICK;
        else if (r < 80) begin
          op = OP_HDR_ACK;
          val = cfg_len;
        end else if (r < 86) op = OP_HDR_ACK;
        else noise = 1'b1;
      end
      default: begin
        noise = 1'b0;
        if (r < 25) op = OP_TICK;
        else if (r < 82) begin
          op = OP_CHUNK_ACK;
          val = {{(LEN_W-CHUNK_W){1'b0}}, cur};
        end else if (r < 87) begin
          op = OP_CHUNK_ACK;
          val = (r < 85) ? val : {{(LEN_W-CHUNK_W){1'b0}}, cur + 1'b1};
        end else noise = 1'b1;
      end
    endcase
    if (noise) op = OP_W'($urandom_range(0, 7));
    send_req(op, val, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      hold_left  <= pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cmd_q.size() == 0) begin
        report_error($sformatf("result with no request outstanding, command %0d", out_tuser));
      end else begin
        oldest = cmd_q.pop_front();
        check_field("command", 32'(out_tuser), 32'(oldest.command));
        check_field("chunk_index", 32'(out_tdata[15:0]), 32'(oldest.chunk_index));
        check_field("chunk_length", 32'(out_tdata[22:16]), 32'(oldest.chunk_length));
        check_field("abort_reason", 32'(out_tdata[24:23]), 32'(oldest.abort_reason));
        check_field("busy_res", 32'(out_tdata[25]), 32'(oldest.busy_res));
        if (oldest.command == CMD_DONE) n_done++;
        if (oldest.command == CMD_ABORT) n_abort++;
      end
      n_results++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results pending", quiet, cmd_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [LEN_W-1:0] len, tmo_word, rty_word;
    int unsigned      r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle cases, empty file, size mismatch
    steps.push_back(typed_row(OP_TICK, '0, res_of(CMD_NONE, '0, '0, RSN_NONE, 1'b0)));
    steps.push_back(typed_row(OP_HDR_ACK, '1, res_of(CMD_NONE, '0, '0, RSN_NONE, 1'b0)));
    steps.push_back(typed_row(OP_START, '0, res_of(CMD_HEADER, '0, '0, RSN_NONE, 1'b1)));
    steps.push_back(typed_row(OP_START, '1, res_of(CMD_NONE, '0, '0, RSN_NONE, 1'b1)));
    steps.push_back(typed_row(OP_HDR_ACK, '0, res_of(CMD_DONE, '0, '0, RSN_NONE, 1'b0)));
    steps.push_back(typed_row(OP_RSVD, '1, res_of(CMD_NONE, '0, '0, RSN_NONE, 1'b0)));
    steps.push_back(typed_row(OP_START, '0, res_of(CMD_HEADER, '0, '0, RSN_NONE, 1'b1)));
    steps.push_back(typed_row(OP_HDR_ACK, 23'd1, res_of(CMD_ABORT, '0, '0, RSN_SIZE, 1'b0)));
    // three chunks, short timeout, one resend allowed
    steps.push_back(cfg_row(23'd130, 16'd1, 8'd1));
    steps.push_back(req_row(OP_START, '0));
    steps.push_back(req_row(OP_TICK, '0));
    steps.push_back(req_row(OP_TICK, '0));
    steps.push_back(req_row(OP_TICK, '0));
    steps.push_back(typed_row(OP_TICK, '0, res_of(CMD_ABORT, '0, '0, RSN_HDR_RTRY, 1'b0)));
    steps.push_back(req_row(OP_START, '0));
    steps.push_back(req_row(OP_HDR_ACK, 23'd130));
    steps.push_back(typed_row(OP_CHUNK_ACK, 23'd1, res_of(CMD_NONE, '0, '0, RSN_NONE, 1'b1)));
    steps.push_back(req_row(OP_OTHER, '0));
    steps.push_back(req_row(OP_CHUNK_ACK, 23'd0));
    steps.push_back(req_row(OP_CHUNK_ACK, 23'd1));
    steps.push_back(req_row(OP_TICK, '0));
    steps.push_back(req_row(OP_TICK, '0));
    steps.push_back(req_row(OP_TICK, '0));
    steps.push_back(typed_row(OP_TICK, '0, res_of(CMD_ABORT, '0, '0, RSN_CHK_RTRY, 1'b0)));
    // zero timeout and zero retries abort on the first tick
    steps.push_back(cfg_row('1, 16'd0, 8'd0));
    steps.push_back(req_row(OP_START, '0));
    steps.push_back(typed_row(OP_TICK, '0, res_of(CMD_ABORT, '0, '0, RSN_HDR_RTRY, 1'b0)));

    foreach (steps[i]) begin
      if (steps[i].reconf) begin
        drain();
        set_config(steps[i].val, {7'd0, steps[i].tmo}, {15'd0, steps[i].rty});
      end else begin
        send_req(steps[i].op, steps[i].val, steps[i].typed, steps[i].want);
      end
    end

    for (int s = 0; s < SESSIONS; s++) begin
      drain();
      r = $urandom_range(0, 99);
      if (r < 30) len = LEN_W'($urandom_range(0, 700));
      else if (r < 50) len = LEN_W'(64 * $urandom_range(0, 10));
      else if (r < 60) len = '0;
      else if (r < 70) len = LEN_W'($urandom_range(701, 3000));
      else if (r < 80) len = LEN_W'($urandom);
      else if (r < 85) len = 23'd4194304;
      else len = LEN_W'($urandom_range(1, 63));
      r = $urandom_range(0, 99);
      if (r < 50) tmo_word = LEN_W'($urandom_range(1, 3));
      else if (r < 65) tmo_word = '0;
      else if (r < 80) tmo_word = LEN_W'($urandom_range(4, 8));
      else if (r < 90) tmo_word = 23'hFFFF;
      else tmo_word = LEN_W'($urandom_range(0, 16'hFFFF));
      tmo_word[LEN_W-1:TICKS_W] = (LEN_W-TICKS_W)'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) rty_word = LEN_W'($urandom_range(0, 2));
      else if (r < 60) rty_word = LEN_W'($urandom_range(3, 6));
      else if (r < 70) rty_word = 23'hFF;
      else if (r < 80) rty_word = '0;
      else rty_word = LEN_W'($urandom_range(0, 255));
      rty_word[LEN_W-1:RETRY_W] = (LEN_W-RETRY_W)'($urandom);
      set_config(len, tmo_word, rty_word);
      no_idle = (s % 5 == 3);
      repeat (SESSION_LEN) random_step();
    end

    // full-size file: full chunks from the start, over the first 16 chunk acks
    drain();
    no_idle = 1'b1;
    set_config('1, 23'hFFFF, '0);
    send_req(OP_START, '0, 1'b0, '0);
    send_req(OP_HDR_ACK, '1, 1'b0, '0);
    for (int unsigned k = 0; k < FULL_ACKS; k++) send_req(OP_CHUNK_ACK, LEN_W'(k), 1'b0, '0);
    drain();
    no_idle = 1'b0;
    repeat (8) @(posedge clk);

    $display("%0d requests, %0d results checked over %0d register settings",
             n_items, n_results, n_cfg);
    $display("%0d transfers completed, %0d aborted; the run ended inside a full-size file",
             n_done, n_abort);
    if (n_err == 0 && cmd_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/swcs_pkg.sv
design/swcs_cfg_regs.sv
design/swcs_engine.sv
design/stop_and_wait_chunk_sender_core.sv
dv/testbench.sv
